// File: hdl/smd_pkg.sv
// smd_pkg: shared types and constants of the stream message deframer
// depends on nothing; imported by every module of the block

package smd_pkg;

   // results one received byte can cause, and the bundle queue depth
   localparam int MAX_RES     = 4;
   localparam int CNT_W       = $clog2(MAX_RES + 1);
   localparam int IDX_W       = $clog2(MAX_RES);
   localparam int QUEUE_DEPTH = 2;

   // characters and limits
   localparam logic [7:0]  CH_COLON  = 8'h3A;
   localparam logic [7:0]  CH_COMMA  = 8'h2C;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;
   localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;

   // framing modes
   localparam logic [1:0] MODE_DELIM     = 2'd0;
   localparam logic [1:0] MODE_NETSTRING = 2'd1;
   localparam logic [1:0] MODE_PREFIX    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FRAME_MODE = 2'd0;
   localparam logic [1:0] CSR_DELIM_WORD = 2'd1;
   localparam logic [1:0] CSR_DELIM_LEN  = 2'd2;
   localparam logic [1:0] CSR_MAX_SIZE   = 2'd3;

   // register reset values
   localparam logic [1:0]  RST_FRAME_MODE = MODE_PREFIX;
   localparam logic [31:0] RST_DELIM_WORD = 32'd10;
   localparam logic [2:0]  RST_DELIM_LEN  = 3'd1;
   localparam logic [30:0] RST_MAX_SIZE   = 31'd1073741824;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_END,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      ERR_SIZE,
      ERR_HEADER,
      ERR_COMMA
   } err_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      err_type    err;
   } slot_type;

   // all results of one request, slot 0 first
   typedef struct packed {
      logic [CNT_W-1:0]           count;
      slot_type [MAX_RES-1:0]     slot;
   } bundle_type;

endpackage

// File: hdl/stream_message_deframer_core.sv
// stream_message_deframer_core: top level of the message deframer
// depends on smd_pkg, smd_front, smd_queue and smd_back
//
// usage:
//  - req_ channel: one received byte per request (req_data_byte), valid/ready
//  - rsp_ channel: one result per response, valid/ready; a request causes zero
//    to four results (payload bytes, end of message, error), the last of them
//    flagged by rsp_last_of_step
//  - csr_ port: write-only, index 0 frame mode, 1 delimiter word, 2 delimiter
//    length, 3 max message size; write only while the block is idle
//  - a request's results are registered in the bundle queue before they show
//  - throughput: one request per cycle while each causes at most one result
//    and rsp_ready stays high; a request with several results holds the
//    response side, its single port draining one bundle slot per cycle
//  - the two-entry bundle queue lets requests keep flowing until it fills
//    while the receiver stalls; req_ready drops only when the queue is full
//  - reset: registers return to length-prefix mode, newline delimiter,
//    1 GiB size limit; framing state cleared, queue emptied
//  - after an error the block keeps taking bytes but gives no results until
//    reset

module stream_message_deframer_core #(
   parameter int MAX_DELIM         = 4,
   parameter int PREFIX_BYTES      = 4,
   parameter int MAX_HEADER_DIGITS = 10,
   parameter int LEN_BITS          = 31
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_step
);
   import smd_pkg::*;

   // front to queue
   logic       push;
   bundle_type push_data;
   logic       space;
   // queue to back
   bundle_type head;
   logic       head_valid;
   logic       pop;

   // front: classifies each byte and builds its result bundle combinationally
   smd_front #(
      .MAX_DELIM        (MAX_DELIM),
      .PREFIX_BYTES     (PREFIX_BYTES),
      .MAX_HEADER_DIGITS(MAX_HEADER_DIGITS),
      .LEN_BITS         (LEN_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .space         (space),
      .push          (push),
      .bundle        (push_data)
   );

   // queue: decouples the request side from response stalls
   smd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .pop       (pop),
      .head      (head),
      .head_valid(head_valid)
   );

   // back: walks the head bundle one result per accepted response
   smd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_step(rsp_last_of_step)
   );

endmodule

// File: hdl/smd_front.sv
// smd_front: configuration registers and framing state; classifies each request
// and builds the bundle of results it causes. depends on smd_pkg

module smd_front #(
   parameter int MAX_DELIM         = 4,
   parameter int PREFIX_BYTES      = 4,
   parameter int MAX_HEADER_DIGITS = 10,
   parameter int LEN_BITS          = 31
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               space,
   output logic               push,
   output smd_pkg::bundle_type bundle
);
   import smd_pkg::*;

   localparam int          CAP      = (MAX_DELIM < 4) ? MAX_DELIM : 4;
   localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_BITS);

   // configuration
   logic [1:0]  mode_ff;
   logic [31:0] dword_ff;
   logic [2:0]  dlen_ff;
   logic [30:0] maxsz_ff;

   // framing state
   phase_type           phase_ff, phase_in;
   logic [2:0]          dm_ff, dm_in;
   logic [LEN_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]         acc_ff, acc_in;
   logic [3:0]          hc_ff, hc_in;
   logic                halted_ff, halted_in;
   logic [7:0]          held_ff [CAP];
   logic                held_we;
   logic [2:0]          held_widx;

   logic        accept;
   logic [7:0]  b;
   logic [31:0] lim;
   logic [31:0] cnt32;
   logic [31:0] room;
   logic        over;
   logic [2:0]  eff;
   logic [2:0]  f;
   logic [2:0]  rel_n;
   logic        d_hit, d_hit_end, d_first, d_rel_fail, d_cur_fail;
   logic [7:0]  held_view [MAX_RES-1];
   logic [LEN_BITS-1:0] cnt_inc, cnt_plus_dm, cnt_plus_dm1;
   logic [31:0] cnt_inc32;
   logic [35:0] acc10_wide;
   logic [31:0] acc10;
   logic [31:0] acc_sh;
   logic [3:0]  hc_inc;
   logic        hdr_done, digit_ok, colon_bad, colon_big;
   logic        mode_write;

   assign b         = req_data_byte;
   assign req_ready = space;
   assign accept    = req_valid && space;
   assign mode_write = csr_write_en && (csr_index == CSR_FRAME_MODE);

   // size limit saturated to the counter range
   assign lim   = ({1'b0, maxsz_ff} > LEN_MASK) ? LEN_MASK : {1'b0, maxsz_ff};
   assign cnt32 = 32'(cnt_ff);
   assign over  = cnt32 >= lim;
   assign room  = lim - cnt32;
   // payload bytes that still fit, capped at four
   assign f = over ? 3'd0 : ((|room[31:2]) ? 3'd4 : {1'b0, room[1:0]});

   // delimiter decode
   always_comb begin
      eff = (dlen_ff == 3'd0) ? 3'd1 : dlen_ff;
      if (eff > 3'(CAP)) eff = 3'(CAP);
   end

   assign d_hit      = (dm_ff < eff) && (b == dword_ff[{dm_ff[1:0], 3'b000} +: 8]);
   assign d_hit_end  = d_hit && ((dm_ff + 3'd1) == eff);
   assign d_first    = b == dword_ff[7:0];
   assign d_rel_fail = f < dm_ff;
   assign d_cur_fail = f == dm_ff;
   assign rel_n      = d_rel_fail ? f : dm_ff;

   for (genvar g = 0; g < MAX_RES - 1; g++) begin : g_view
      if (g < CAP) begin : g_used
         assign held_view[g] = held_ff[g];
      end else begin : g_none
         assign held_view[g] = 8'h00;
      end
   end

   assign cnt_inc      = cnt_ff + LEN_BITS'(1);
   assign cnt_inc32    = 32'(cnt_inc);
   assign cnt_plus_dm  = cnt_ff + LEN_BITS'(dm_ff);
   assign cnt_plus_dm1 = cnt_plus_dm + LEN_BITS'(1);

   // netstring header: times ten plus digit, saturated to 32 bits
   assign acc10_wide = 36'({acc_ff, 3'b000}) + 36'({acc_ff, 1'b0}) + 36'(b - CH_ZERO);
   assign acc10      = (|acc10_wide[35:32]) ? 32'hFFFF_FFFF : acc10_wide[31:0];
   assign digit_ok   = (b >= CH_ZERO) && (b <= CH_NINE) && (hc_ff < 4'(MAX_HEADER_DIGITS));
   assign colon_bad  = (hc_ff == 4'd0) || (acc_ff > INT_LIMIT);
   assign colon_big  = acc_ff > lim;

   // length prefix header
   assign acc_sh   = {acc_ff[23:0], b};
   assign hc_inc   = hc_ff + 4'd1;
   assign hdr_done = hc_inc >= 4'(PREFIX_BYTES);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      dm_in     = dm_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      hc_in     = hc_ff;
      halted_in = halted_ff;
      held_we   = 1'b0;
      held_widx = dm_ff;
      if (mode_write) begin
         phase_in = PH_HEADER;
         dm_in    = 3'd0;
         cnt_in   = '0;
         acc_in   = '0;
         hc_in    = '0;
      end else if (accept && !halted_ff) begin
         unique case (mode_ff)
            MODE_DELIM: begin
               if (d_hit) begin
                  held_we = 1'b1;
                  if (d_hit_end) begin
                     dm_in  = 3'd0;
                     cnt_in = '0;
                  end else begin
                     dm_in = dm_ff + 3'd1;
                  end
               end else if (d_rel_fail) begin
                  halted_in = 1'b1;
               end else if (d_first) begin
                  held_we   = 1'b1;
                  held_widx = 3'd0;
                  if (eff == 3'd1) begin
                     dm_in  = 3'd0;
                     cnt_in = '0;
                  end else begin
                     dm_in  = 3'd1;
                     cnt_in = cnt_plus_dm;
                  end
               end else if (d_cur_fail) begin
                  halted_in = 1'b1;
               end else begin
                  dm_in  = 3'd0;
                  cnt_in = cnt_plus_dm1;
               end
            end
            MODE_NETSTRING: begin
               unique case (phase_ff)
                  PH_PAYLOAD: begin
                     cnt_in = cnt_inc;
                     if (cnt_inc32 >= acc_ff) phase_in = PH_TRAILER;
                  end
                  PH_TRAILER: begin
                     if (b == CH_COMMA) begin
                        phase_in = PH_HEADER;
                        dm_in    = 3'd0;
                        cnt_in   = '0;
                        acc_in   = '0;
                        hc_in    = '0;
                     end else begin
                        halted_in = 1'b1;
                     end
                  end
                  default: begin
                     if (b == CH_COLON) begin
                        if (colon_bad || colon_big) begin
                           halted_in = 1'b1;
                        end else begin
                           hc_in    = '0;
                           cnt_in   = '0;
                           phase_in = (acc_ff == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                     end else if (digit_ok) begin
                        acc_in = acc10;
                        hc_in  = hc_inc;
                     end else begin
                        halted_in = 1'b1;
                     end
                  end
               endcase
            end
            MODE_PREFIX: begin
               if (phase_ff == PH_PAYLOAD) begin
                  cnt_in = cnt_inc;
                  if (cnt_inc32 >= acc_ff) begin
                     phase_in = PH_HEADER;
                     dm_in    = 3'd0;
                     cnt_in   = '0;
                     acc_in   = '0;
                     hc_in    = '0;
                  end
               end else begin
                  acc_in = acc_sh;
                  hc_in  = hc_inc;
                  if (hdr_done) begin
                     hc_in  = '0;
                     cnt_in = '0;
                     if (acc_sh > lim) begin
                        halted_in = 1'b1;
                     end else if (acc_sh == 32'd0) begin
                        phase_in = PH_HEADER;
                        dm_in    = 3'd0;
                        acc_in   = '0;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // results of this request
   always_comb begin
      bundle = '0;
      if (!halted_ff) begin
         unique case (mode_ff)
            MODE_DELIM: begin
               if (d_hit) begin
                  if (d_hit_end) begin
                     bundle.slot[0].kind = KIND_END;
                     bundle.count        = CNT_W'(1);
                  end
               end else begin
                  for (int i = 0; i < MAX_RES - 1; i++) begin
                     if (3'(i) < rel_n) begin
                        bundle.slot[i].kind = KIND_PAYLOAD;
                        bundle.slot[i].data = held_view[i];
                     end
                  end
                  bundle.count = CNT_W'(rel_n);
                  if (d_rel_fail) begin
                     bundle.slot[rel_n[IDX_W-1:0]].kind = KIND_ERROR;
                     bundle.slot[rel_n[IDX_W-1:0]].err  = ERR_SIZE;
                     bundle.count = CNT_W'(rel_n) + CNT_W'(1);
                  end else if (d_first) begin
                     if (eff == 3'd1) begin
                        bundle.slot[dm_ff[IDX_W-1:0]].kind = KIND_END;
                        bundle.count = CNT_W'(dm_ff) + CNT_W'(1);
                     end
                  end else if (d_cur_fail) begin
                     bundle.slot[dm_ff[IDX_W-1:0]].kind = KIND_ERROR;
                     bundle.slot[dm_ff[IDX_W-1:0]].err  = ERR_SIZE;
                     bundle.count = CNT_W'(dm_ff) + CNT_W'(1);
                  end else begin
                     bundle.slot[dm_ff[IDX_W-1:0]].kind = KIND_PAYLOAD;
                     bundle.slot[dm_ff[IDX_W-1:0]].data = b;
                     bundle.count = CNT_W'(dm_ff) + CNT_W'(1);
                  end
               end
            end
            MODE_NETSTRING: begin
               unique case (phase_ff)
                  PH_PAYLOAD: begin
                     bundle.slot[0].kind = KIND_PAYLOAD;
                     bundle.slot[0].data = b;
                     bundle.count        = CNT_W'(1);
                  end
                  PH_TRAILER: begin
                     if (b == CH_COMMA) begin
                        bundle.slot[0].kind = KIND_END;
                     end else begin
                        bundle.slot[0].kind = KIND_ERROR;
                        bundle.slot[0].err  = ERR_COMMA;
                     end
                     bundle.count = CNT_W'(1);
                  end
                  default: begin
                     if (b == CH_COLON) begin
                        if (colon_bad) begin
                           bundle.slot[0].kind = KIND_ERROR;
                           bundle.slot[0].err  = ERR_HEADER;
                           bundle.count        = CNT_W'(1);
                        end else if (colon_big) begin
                           bundle.slot[0].kind = KIND_ERROR;
                           bundle.slot[0].err  = ERR_SIZE;
                           bundle.count        = CNT_W'(1);
                        end
                     end else if (!digit_ok) begin
                        bundle.slot[0].kind = KIND_ERROR;
                        bundle.slot[0].err  = ERR_HEADER;
                        bundle.count        = CNT_W'(1);
                     end
                  end
               endcase
            end
            MODE_PREFIX: begin
               if (phase_ff == PH_PAYLOAD) begin
                  bundle.slot[0].kind = KIND_PAYLOAD;
                  bundle.slot[0].data = b;
                  bundle.count        = CNT_W'(1);
                  if (cnt_inc32 >= acc_ff) begin
                     bundle.slot[1].kind = KIND_END;
                     bundle.count        = CNT_W'(2);
                  end
               end else if (hdr_done) begin
                  if (acc_sh > lim) begin
                     bundle.slot[0].kind = KIND_ERROR;
                     bundle.slot[0].err  = ERR_SIZE;
                     bundle.count        = CNT_W'(1);
                  end else if (acc_sh == 32'd0) begin
                     bundle.slot[0].kind = KIND_END;
                     bundle.count        = CNT_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign push = accept && (bundle.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= RST_FRAME_MODE;
         dword_ff <= RST_DELIM_WORD;
         dlen_ff  <= RST_DELIM_LEN;
         maxsz_ff <= RST_MAX_SIZE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_MODE: mode_ff  <= csr_write_data[1:0];
            CSR_DELIM_WORD: dword_ff <= csr_write_data;
            CSR_DELIM_LEN:  dlen_ff  <= csr_write_data[2:0];
            CSR_MAX_SIZE:   maxsz_ff <= csr_write_data[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         dm_ff     <= 3'd0;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         hc_ff     <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         dm_ff     <= dm_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         hc_ff     <= hc_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CAP; j++) begin
         if (held_we && (held_widx == 3'(j))) held_ff[j] <= b;
      end
   end

   // an error stops the block until reset
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag dropped without reset");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      dm_ff < 3'(CAP) || dm_ff == 3'(CAP - 1))
      else $error("delimiter match count beyond held storage");

   a_phase_mode: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> mode_ff == MODE_NETSTRING || mode_ff == MODE_PREFIX)
      else $error("payload phase outside a length-based mode");

endmodule

// File: hdl/smd_queue.sv
// smd_queue: short queue of result bundles between front and back
// depends on smd_pkg

module smd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smd_pkg::bundle_type push_data,
   output logic                space,
   input  logic                pop,
   output smd_pkg::bundle_type head,
   output logic                head_valid
);
   import smd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type       q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [OCC_W-1:0] occ_ff, occ_in;

   assign space      = occ_ff != OCC_W'(QUEUE_DEPTH);
   assign head_valid = occ_ff != '0;
   assign head       = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      occ_in = occ_ff;
      if (push) wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      priority case ({push, pop})
         2'b10:   occ_in = occ_ff + OCC_W'(1);
         2'b01:   occ_in = occ_ff - OCC_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         occ_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> occ_ff != OCC_W'(QUEUE_DEPTH))
      else $error("bundle pushed into full queue");

endmodule

// File: hdl/smd_back.sv
// smd_back: hands out the results of the head bundle one per response
// depends on smd_pkg

module smd_back (
   input  logic                clock,
   input  logic                reset,
   input  smd_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_result_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_last_of_step
);
   import smd_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   slot_type         cur;
   logic             take;

   assign cur              = head.slot[idx_ff];
   assign rsp_valid        = head_valid;
   assign rsp_result_kind  = cur.kind;
   assign rsp_payload_byte = cur.data;
   assign rsp_error_code   = cur.err;
   assign rsp_last_of_step = (CNT_W'(idx_ff) + CNT_W'(1)) == head.count;

   assign take = rsp_valid && rsp_ready;
   assign pop  = take && rsp_last_of_step;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = rsp_last_of_step ? '0 : idx_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> CNT_W'(idx_ff) < head.count)
      else $error("response slot beyond bundle count");

endmodule
